// ===== design/sfd_pkg.sv =====
package sfd_pkg;

    localparam int MAX_PAYLOAD = 32;

    // Widths of the register and payload fields
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 6;
    localparam int INDEX_W  = 5;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = $clog2(MAX_PAYLOAD + 1);
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STALE_CHECK    = 2'd2;

    // Register reset values
    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hAA;
    localparam logic [LEN_W-1:0]  LENGTH_RESET = 6'd20;
    localparam logic              STALE_RESET  = 1'b1;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    // Frame status codes
    localparam logic [STATUS_W-1:0] ST_GOOD  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_STALE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD   = 2'd2;

    typedef struct packed {
        logic                valid;
        logic                kind;
        logic [INDEX_W-1:0]  index;
        logic [BYTE_W-1:0]   value;
        logic [STATUS_W-1:0] status;
        logic                last;
    } sfd_result_t;

    // Clamp the programmed length into 1..MAX_PAYLOAD
    function automatic logic [COUNT_W-1:0] eff_length(input logic [LEN_W-1:0] len);
        logic [COUNT_W-1:0] n;
        if (len == '0) begin
            n = COUNT_W'(1);
        end else if (32'(len) > MAX_PAYLOAD) begin
            n = COUNT_W'(MAX_PAYLOAD);
        end else begin
            n = COUNT_W'(len);
        end
        return n;
    endfunction

endpackage

// ===== design/sequenced_frame_deframer_unit.sv =====
// Sequenced frame deframer with an 8-bit additive checksum.
//
// Input channel (s_valid/s_ready/s_rx_byte): one received link byte per
// transaction. The block hunts for two header bytes, takes a sequence byte,
// payload_length payload bytes (clamped to 1..MAX_PAYLOAD) and a checksum byte.
// Result channel (m_valid/m_ready/m_*): one transaction per payload byte
// (kind 0, with its index) and one end-of-frame transaction (kind 1) with
// status good, stale sequence or bad checksum. Header bytes, accepted sequence
// bytes and broken headers produce nothing.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): write
// header_byte (0), payload_length (1), stale_check (2) while idle; always ready.
// Latency: a result is presented the cycle after its byte is accepted.
// Throughput: one byte per cycle while s_ready is high; the parse step is one compare, one add and
// a phase update between the state registers and the result register.
// Stall: s_ready drops only while a result sits in the output register and
// m_ready is low; the held result stays unchanged until taken.
// Reset: aresetn (synchronous, active low) restores register defaults
// (0xAA, 20, 1), returns to header hunt and clears the last sequence to 0.
module sequenced_frame_deframer_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    // received byte channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [sfd_pkg::BYTE_W-1:0]     s_rx_byte,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_result_kind,
    output logic [sfd_pkg::INDEX_W-1:0]    m_payload_index,
    output logic [sfd_pkg::BYTE_W-1:0]     m_payload_value,
    output logic [sfd_pkg::STATUS_W-1:0]   m_frame_status,
    output logic                           m_frame_last,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfd_pkg::BYTE_W-1:0]     cfg_data
);
    import sfd_pkg::*;

    logic [BYTE_W-1:0] header_reg;
    logic [LEN_W-1:0]  length_reg;
    logic              stale_reg;

    logic        byte_take;
    sfd_result_t result;
    sfd_result_t out_reg;
    logic        out_valid_reg, out_valid_next;

    // Accept a byte whenever the output slot is free or drains this cycle
    assign s_ready   = !out_valid_reg || m_ready;
    assign byte_take = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // Configuration registers; unknown index is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg <= HEADER_RESET;
            length_reg <= LENGTH_RESET;
            stale_reg  <= STALE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_HEADER_BYTE:    header_reg <= cfg_data;
                REG_PAYLOAD_LENGTH: length_reg <= cfg_data[LEN_W-1:0];
                REG_STALE_CHECK:    stale_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    sfd_parser u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .byte_take      (byte_take),
        .rx_byte        (s_rx_byte),
        .header_byte    (header_reg),
        .payload_length (length_reg),
        .stale_check    (stale_reg),
        .result         (result)
    );

    // Output register: load a fresh result, otherwise hold until taken
    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (result.valid) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload half needs no reset
    always_ff @(posedge aclk) begin
        if (result.valid) begin
            out_reg <= result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_result_kind   = out_reg.kind;
    assign m_payload_index = out_reg.index;
    assign m_payload_value = out_reg.value;
    assign m_frame_status  = out_reg.status;
    assign m_frame_last    = out_reg.last;

    a_free_slot_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_ready)
        else $error("input stalled with empty output slot");

    a_last_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_frame_last == m_result_kind)
        else $error("frame_last disagrees with result kind");

    a_payload_good: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == KIND_PAYLOAD |-> m_frame_status == ST_GOOD)
        else $error("payload result carries a nonzero status");

    a_end_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == KIND_END
        |-> m_payload_index == '0 && m_payload_value == '0)
        else $error("end-of-frame result carries payload data");

endmodule

// ===== design/sfd_parser.sv =====
module sfd_parser (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        byte_take,
    input  logic [sfd_pkg::BYTE_W-1:0]  rx_byte,
    input  logic [sfd_pkg::BYTE_W-1:0]  header_byte,
    input  logic [sfd_pkg::LEN_W-1:0]   payload_length,
    input  logic                        stale_check,
    output sfd_pkg::sfd_result_t        result
);
    import sfd_pkg::*;

    localparam logic [2:0] PH_HUNT1 = 3'd0;
    localparam logic [2:0] PH_HUNT2 = 3'd1;
    localparam logic [2:0] PH_SEQ   = 3'd2;
    localparam logic [2:0] PH_DATA  = 3'd3;
    localparam logic [2:0] PH_CHECK = 3'd4;

    logic [2:0]         phase_reg, phase_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [BYTE_W-1:0]  sum_reg, sum_next;
    logic [BYTE_W-1:0]  last_seq_reg, last_seq_next;
    logic [COUNT_W-1:0] eff_len;
    logic [COUNT_W-1:0] count_inc;
    logic               take_checksum;
    sfd_result_t        res;

    assign eff_len   = eff_length(payload_length);
    assign count_inc = count_reg + COUNT_W'(1);

    always_comb begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        last_seq_next = last_seq_reg;
        take_checksum = 1'b0;
        res           = '0;
        unique case (phase_reg)
            PH_HUNT1: begin
                if (rx_byte == header_byte) begin
                    sum_next   = rx_byte;
                    phase_next = PH_HUNT2;
                end
            end
            PH_HUNT2: begin
                if (rx_byte == header_byte) begin
                    sum_next   = sum_reg + rx_byte;
                    phase_next = PH_SEQ;
                end else begin
                    phase_next = PH_HUNT1;
                end
            end
            PH_SEQ: begin
                if (stale_check && rx_byte == last_seq_reg) begin
                    phase_next = PH_HUNT1;
                    res.valid  = 1'b1;
                    res.kind   = KIND_END;
                    res.status = ST_STALE;
                    res.last   = 1'b1;
                end else begin
                    last_seq_next = rx_byte;
                    sum_next      = sum_reg + rx_byte;
                    count_next    = '0;
                    phase_next    = PH_DATA;
                end
            end
            PH_DATA: begin
                // length may have shrunk below what was taken: treat as checksum
                if (count_reg >= eff_len) begin
                    take_checksum = 1'b1;
                end else begin
                    res.valid  = 1'b1;
                    res.kind   = KIND_PAYLOAD;
                    res.index  = count_reg[INDEX_W-1:0];
                    res.value  = rx_byte;
                    sum_next   = sum_reg + rx_byte;
                    count_next = count_inc;
                    if (count_inc >= eff_len) begin
                        phase_next = PH_CHECK;
                    end
                end
            end
            PH_CHECK: begin
                take_checksum = 1'b1;
            end
            default: begin
                phase_next = PH_HUNT1;
            end
        endcase

        if (take_checksum) begin
            phase_next = PH_HUNT1;
            res.valid  = 1'b1;
            res.kind   = KIND_END;
            res.status = (rx_byte == sum_reg) ? ST_GOOD : ST_BAD;
            res.last   = 1'b1;
        end
    end

    assign result = byte_take ? res : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HUNT1;
            count_reg    <= '0;
            sum_reg      <= '0;
            last_seq_reg <= '0;
        end else if (byte_take) begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            last_seq_reg <= last_seq_next;
        end
    end

    // Check phase is only entered after at least one payload byte was taken
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_CHECK |-> count_reg != '0)
        else $error("check phase entered with no payload taken");

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(MAX_PAYLOAD))
        else $error("payload count beyond maximum");

    a_stale_keeps_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_take && result.valid && result.status == ST_STALE
        |=> last_seq_reg == $past(last_seq_reg))
        else $error("stale frame overwrote last sequence");

endmodule
